// ===== hdl/bcsc_pkg.sv =====
`default_nettype none

package bcsc_pkg;

   // limits on the image geometry
   localparam int unsigned MAX_DIM = 16384;
   localparam int unsigned MAX_BPP = 4;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_HEADER_LEN  = 3'd0;
   localparam logic [2:0] CSR_IMG_WIDTH   = 3'd1;
   localparam logic [2:0] CSR_IMG_HEIGHT  = 3'd2;
   localparam logic [2:0] CSR_BPP         = 3'd3;
   localparam logic [2:0] CSR_STRIP_PX    = 3'd4;

   // reset values of the registers
   localparam logic [9:0]  RST_HEADER_LEN  = 10'd54;
   localparam logic [14:0] RST_IMG_WIDTH   = 15'd1;
   localparam logic [14:0] RST_IMG_HEIGHT  = 15'd1;
   localparam logic [2:0]  RST_BPP         = 3'd3;
   localparam logic [14:0] RST_STRIP_PX    = 15'd1;

   // header fields that get rewritten (4 bytes each, little-endian)
   localparam logic [9:0] OFS_FILE_SIZE = 10'd2;
   localparam logic [9:0] OFS_WIDTH     = 10'd18;
   localparam logic [9:0] OFS_DATA_SIZE = 10'd34;
   localparam logic [9:0] FIELD_BYTES   = 10'd4;

   // cycles the geometry pipeline needs after a register write
   localparam logic [2:0] SETTLE_CYCLES = 3'd5;

   // default depth of the front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 4;

   // derived geometry from the effective (saturated) settings; the header length is kept as written
   typedef struct packed {
      logic [9:0]  header_len;
      logic [14:0] sw;          // strip width in pixels
      logic [14:0] h;           // image height in rows
      logic [1:0]  spad;        // padding after each strip row
      logic [16:0] irow;        // input row length incl. padding
      logic [16:0] s0;          // first strip byte in a row
      logic [16:0] s1;          // one past the last strip byte
      logic [31:0] fsize;       // new file size
      logic [31:0] dsize;       // new unpadded pixel data size
   } bcsc_geom_type;

   // one queued word: a data byte and the zero padding behind it
   typedef struct packed {
      logic [7:0] data;
      logic       data_last;
      logic [1:0] pad_cnt;
      logic       pad_last;
   } bcsc_entry_type;

endpackage

`default_nettype wire

// ===== hdl/bcsc_cfg.sv =====
`default_nettype none

module bcsc_cfg
   import bcsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [14:0]   csr_data,
   output bcsc_geom_type      geom,
   output logic               busy
);

   logic [9:0]  header_len_ff, header_len_in;
   logic [14:0] img_width_ff, img_width_in;
   logic [14:0] img_height_ff, img_height_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [14:0] strip_px_ff, strip_px_in;
   logic [2:0]  settle_ff, settle_in;

   // stage A: saturated settings
   logic [14:0] w_a_ff, w_a_in, h_a_ff, h_a_in, sw_a_ff, sw_a_in;
   logic [2:0]  b_a_ff, b_a_in;
   // stage B: products
   logic [16:0] srow_b_ff, srow_b_in, wb_b_ff, wb_b_in, s0_b_ff, s0_b_in;
   // stage C: row lengths
   logic [1:0]  spad_c_ff, spad_c_in;
   logic [16:0] irow_c_ff, irow_c_in, s1_c_ff, s1_c_in;
   logic [16:0] srowpad_c_ff, srowpad_c_in, srow_c_ff, srow_c_in;
   // stage D: sizes
   logic [30:0] fprod_d_ff, fprod_d_in, dsize_d_ff, dsize_d_in;
   // stage E: file size
   logic [31:0] fsize_e_ff, fsize_e_in;

   logic        wr;
   logic [14:0] sw_c;
   logic [13:0] half;
   logic [1:0]  wpad;

   function automatic logic [14:0] clamp_dim(input logic [14:0] v);
      logic [14:0] r;
      if (v == 15'd0) begin
         r = 15'd1;
      end else if (v > 15'(MAX_DIM)) begin
         r = 15'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign busy      = (settle_ff != 3'd0);

   // register writes; every write restarts the settle count
   always_comb begin
      header_len_in  = header_len_ff;
      img_width_in   = img_width_ff;
      img_height_in  = img_height_ff;
      bpp_in         = bpp_ff;
      strip_px_in    = strip_px_ff;
      settle_in      = busy ? settle_ff - 3'd1 : settle_ff;
      if (wr) begin
         settle_in = SETTLE_CYCLES;
         unique case (csr_index)
            CSR_HEADER_LEN:  header_len_in  = csr_data[9:0];
            CSR_IMG_WIDTH:   img_width_in   = csr_data;
            CSR_IMG_HEIGHT:  img_height_in  = csr_data;
            CSR_BPP:         bpp_in         = csr_data[2:0];
            CSR_STRIP_PX:    strip_px_in    = csr_data;
            default: ;
         endcase
      end
   end

   // geometry pipeline
   always_comb begin
      w_a_in = clamp_dim(img_width_ff);
      h_a_in = clamp_dim(img_height_ff);
      sw_c   = clamp_dim(strip_px_ff);
      sw_a_in = (sw_c > w_a_in) ? w_a_in : sw_c;
      if (bpp_ff == 3'd0) begin
         b_a_in = 3'd1;
      end else if (bpp_ff > 3'(MAX_BPP)) begin
         b_a_in = 3'(MAX_BPP);
      end else begin
         b_a_in = bpp_ff;
      end

      half      = 14'((w_a_ff - sw_a_ff) >> 1);
      srow_b_in = 17'(17'(sw_a_ff) * 17'(b_a_ff));
      wb_b_in   = 17'(17'(w_a_ff) * 17'(b_a_ff));
      s0_b_in   = 17'(17'(half) * 17'(b_a_ff));

      spad_c_in    = 2'd0 - srow_b_ff[1:0];
      wpad         = 2'd0 - wb_b_ff[1:0];
      irow_c_in    = wb_b_ff + 17'(wpad);
      s1_c_in      = s0_b_ff + srow_b_ff;
      srowpad_c_in = srow_b_ff + 17'(spad_c_in);
      srow_c_in    = srow_b_ff;

      fprod_d_in = 31'(31'(h_a_ff) * 31'(srowpad_c_ff));
      dsize_d_in = 31'(31'(h_a_ff) * 31'(srow_c_ff));

      fsize_e_in = 32'(header_len_ff) + 32'(fprod_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_len_ff  <= RST_HEADER_LEN;
         img_width_ff   <= RST_IMG_WIDTH;
         img_height_ff  <= RST_IMG_HEIGHT;
         bpp_ff         <= RST_BPP;
         strip_px_ff    <= RST_STRIP_PX;
         settle_ff      <= SETTLE_CYCLES;
      end else begin
         header_len_ff  <= header_len_in;
         img_width_ff   <= img_width_in;
         img_height_ff  <= img_height_in;
         bpp_ff         <= bpp_in;
         strip_px_ff    <= strip_px_in;
         settle_ff      <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      w_a_ff       <= w_a_in;
      h_a_ff       <= h_a_in;
      sw_a_ff      <= sw_a_in;
      b_a_ff       <= b_a_in;
      srow_b_ff    <= srow_b_in;
      wb_b_ff      <= wb_b_in;
      s0_b_ff      <= s0_b_in;
      spad_c_ff    <= spad_c_in;
      irow_c_ff    <= irow_c_in;
      s1_c_ff      <= s1_c_in;
      srowpad_c_ff <= srowpad_c_in;
      srow_c_ff    <= srow_c_in;
      fprod_d_ff   <= fprod_d_in;
      dsize_d_ff   <= dsize_d_in;
      fsize_e_ff   <= fsize_e_in;
   end

   always_comb begin
      geom.header_len = header_len_ff;
      geom.sw         = sw_a_ff;
      geom.h          = h_a_ff;
      geom.spad       = spad_c_ff;
      geom.irow       = irow_c_ff;
      geom.s0         = s0_b_ff;
      geom.s1         = s1_c_ff;
      geom.fsize      = fsize_e_ff;
      geom.dsize      = 32'(dsize_d_ff);
   end

endmodule

`default_nettype wire

// ===== hdl/bcsc_front.sv =====
`default_nettype none

module bcsc_front
   import bcsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,
   input  wire logic          req_tuser,
   input  wire bcsc_geom_type geom,
   input  wire logic          hold,
   output logic               push,
   output bcsc_entry_type     entry
);

   logic [9:0]  header_pos_ff, header_pos_in;
   logic [13:0] row_index_ff, row_index_in;
   logic [16:0] row_byte_pos_ff, row_byte_pos_in;
   logic        file_done_ff, file_done_in;

   logic        accept;
   logic [9:0]  hp;
   logic [13:0] ri;
   logic [16:0] p;
   logic        done;
   logic        in_header;
   logic [1:0]  sel;
   logic [31:0] field;
   logic        use_field;
   logic [17:0] p_next;
   logic        in_strip;
   logic        row_end;
   logic        last_row;

   assign req_tready = !hold;
   assign accept     = req_tvalid && req_tready;

   // a first-byte mark clears the counters before the byte is classified
   always_comb begin
      hp   = req_tuser ? 10'd0 : header_pos_ff;
      ri   = req_tuser ? 14'd0 : row_index_ff;
      p    = req_tuser ? 17'd0 : row_byte_pos_ff;
      done = req_tuser ? 1'b0  : file_done_ff;
   end

   // header byte substitution
   always_comb begin
      in_header = (hp < geom.header_len);
      sel       = hp[1:0] - 2'd2;
      use_field = 1'b1;
      if (hp >= OFS_FILE_SIZE && hp < OFS_FILE_SIZE + FIELD_BYTES) begin
         field = geom.fsize;
      end else if (hp >= OFS_WIDTH && hp < OFS_WIDTH + FIELD_BYTES) begin
         field = 32'(geom.sw);
      end else if (hp >= OFS_DATA_SIZE && hp < OFS_DATA_SIZE + FIELD_BYTES) begin
         field = geom.dsize;
      end else begin
         field     = '0;
         use_field = 1'b0;
      end
   end

   // pixel row position
   always_comb begin
      in_strip = (p >= geom.s0) && (p < geom.s1);
      p_next   = {1'b0, p} + 18'd1;
      row_end  = (p_next == {1'b0, geom.s1});
      last_row = (({1'b0, ri} + 15'd1) >= geom.h);
   end

   // classify the word and advance the counters
   always_comb begin
      header_pos_in   = header_pos_ff;
      row_index_in    = row_index_ff;
      row_byte_pos_in = row_byte_pos_ff;
      file_done_in    = file_done_ff;
      push            = 1'b0;
      entry.data      = req_tdata;
      entry.data_last = 1'b0;
      entry.pad_cnt   = 2'd0;
      entry.pad_last  = 1'b0;
      // fields are only rewritten while still inside the header
      if (in_header && use_field) begin
         unique case (sel)
            2'd0: entry.data = field[7:0];
            2'd1: entry.data = field[15:8];
            2'd2: entry.data = field[23:16];
            2'd3: entry.data = field[31:24];
            default: entry.data = field[7:0];
         endcase
      end
      if (!in_header) begin
         entry.data_last = row_end && last_row && (geom.spad == 2'd0);
         entry.pad_cnt   = row_end ? geom.spad : 2'd0;
         entry.pad_last  = last_row;
      end
      if (accept) begin
         header_pos_in   = hp;
         row_index_in    = ri;
         row_byte_pos_in = p;
         file_done_in    = done;
         if (!done) begin
            if (in_header) begin
               push          = 1'b1;
               header_pos_in = hp + 10'd1;
            end else begin
               push = in_strip;
               if (in_strip && row_end && last_row) begin
                  file_done_in = 1'b1;
               end
               if (p_next >= {1'b0, geom.irow}) begin
                  row_byte_pos_in = 17'd0;
                  row_index_in    = ri + 14'd1;
               end else begin
                  row_byte_pos_in = p_next[16:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff   <= '0;
         row_index_ff    <= '0;
         row_byte_pos_ff <= '0;
         file_done_ff    <= 1'b0;
      end else begin
         header_pos_ff   <= header_pos_in;
         row_index_ff    <= row_index_in;
         row_byte_pos_ff <= row_byte_pos_in;
         file_done_ff    <= file_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bcsc_queue.sv =====
`default_nettype none

module bcsc_queue
   import bcsc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire bcsc_entry_type push_entry,
   input  wire logic           pop,
   output bcsc_entry_type      head,
   output logic                full,
   output logic                empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   bcsc_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bcsc_back.sv =====
`default_nettype none

module bcsc_back
   import bcsc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bcsc_entry_type head,
   input  wire logic           empty,
   output logic                pop,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [1:0] pad_left_ff, pad_left_in;
   logic       pad_last_ff, pad_last_in;
   logic       load;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   // output register refills when empty or when its word is taken
   assign load = !valid_ff || rsp_tready;

   // pending padding goes out before the next queued word
   always_comb begin
      valid_in    = valid_ff;
      data_in     = data_ff;
      last_in     = last_ff;
      pad_left_in = pad_left_ff;
      pad_last_in = pad_last_ff;
      pop         = 1'b0;
      if (load) begin
         if (pad_left_ff != 2'd0) begin
            valid_in    = 1'b1;
            data_in     = 8'd0;
            last_in     = pad_last_ff && (pad_left_ff == 2'd1);
            pad_left_in = pad_left_ff - 2'd1;
         end else if (!empty) begin
            pop         = 1'b1;
            valid_in    = 1'b1;
            data_in     = head.data;
            last_in     = head.data_last;
            pad_left_in = head.pad_cnt;
            pad_last_in = head.pad_last;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pad_left_ff <= 2'd0;
      end else begin
         valid_ff    <= valid_in;
         pad_left_ff <= pad_left_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      last_ff     <= last_in;
      pad_last_ff <= pad_last_in;
   end

endmodule

`default_nettype wire

// ===== hdl/bmp_center_strip_crop.sv =====
`default_nettype none

// Streams an uncompressed BMP file in, one byte per word, and streams out a
// BMP holding only the centred vertical strip of every row, with the file
// size, width and pixel data size fields of the header rewritten. Mark the
// first byte of each file on req_tuser; rsp_tlast marks the final output byte
// and later input bytes are dropped until the next first-byte mark. An input
// word is taken every cycle while the output keeps up; the last strip byte of
// a row brings up to three zero padding bytes with it, sent one per cycle from
// the output register while rsp_tready is high, and the queue between
// classifier and output absorbs those bursts. After reset and after each csr
// write the input is held off while the registered geometry pipeline (two
// multiplier stages) settles. csr writes are taken every cycle.
module bmp_center_strip_crop
   import bcsc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tuser,    // [0] first_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] out_byte
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   bcsc_geom_type  geom;
   bcsc_entry_type push_entry;
   bcsc_entry_type head;
   logic           cfg_busy;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;
   logic           hold;

   assign hold = cfg_busy || q_full;

   bcsc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .busy      (cfg_busy)
   );

   bcsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .geom       (geom),
      .hold       (hold),
      .push       (q_push),
      .entry      (push_entry)
   );

   bcsc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   bcsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a register write holds off input while the geometry settles
   a_csr_holds_input: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !(req_tvalid && req_tready))
      else $error("input word taken straight after a csr write");

   // input stays held off just after reset
   a_reset_settle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input ready before geometry settled");

   // the output stage never pulls from an empty queue
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // the queue is never written while full
   a_no_full_push: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bcsc_pkg::*;

   localparam int RANDOM_WORDS   = 50;
   localparam int SETTLE_WAIT    = 12;    // lets the geometry pipeline settle, plus margin
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = CSR_HEADER_LEN;
   logic [14:0] csr_data   = 15'd0;

   // one output word as predicted
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } strip_byte_type;

   // Predicts the strip file from the input bytes and checks the output words
   class strip_scoreboard;
      logic [9:0]    header_len;
      logic [14:0]   img_width;
      logic [14:0]   img_height;
      logic [2:0]    bpp_reg;
      logic [14:0]   strip_px;
      logic [9:0]    header_pos;
      logic [13:0]   row_index;
      logic [16:0]   row_byte_pos;
      bit            file_done;
      // effective geometry
      int unsigned   w, h, bpp, sw, srow, spad, irow, s0, s1, fsize, dsize;
      strip_byte_type expected_q[$];
      int            n_mismatch;
      int            n_checked;
      int            n_inputs;
      int            n_writes;

      function new();
         header_len   = RST_HEADER_LEN;
         img_width    = RST_IMG_WIDTH;
         img_height   = RST_IMG_HEIGHT;
         bpp_reg      = RST_BPP;
         strip_px     = RST_STRIP_PX;
         header_pos   = '0;
         row_index    = '0;
         row_byte_pos = '0;
         file_done    = 1'b0;
         n_mismatch   = 0;
         n_checked    = 0;
         n_inputs     = 0;
         n_writes     = 0;
         update_geom();
      endfunction

      // zero counts as one, large values clip
      function int unsigned sat(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void update_geom();
         w   = sat(img_width, MAX_DIM);
         h   = sat(img_height, MAX_DIM);
         bpp = sat(bpp_reg, MAX_BPP);
         sw  = sat(strip_px, MAX_DIM);
         if (sw > w) sw = w;
         srow  = sw * bpp;
         spad  = (4 - (srow & 3)) & 3;
         irow  = w * bpp + ((4 - ((w * bpp) & 3)) & 3);
         s0    = ((w - sw) / 2) * bpp;
         s1    = s0 + srow;
         fsize = header_len + h * (srow + spad);
         dsize = h * srow;
      endfunction

      function int unsigned file_len();
         return header_len + h * irow;
      endfunction

      function void write_reg(logic [2:0] index, logic [14:0] value);
         n_writes++;
         case (index)
            CSR_HEADER_LEN:  header_len  = value[9:0];
            CSR_IMG_WIDTH:   img_width   = value;
            CSR_IMG_HEIGHT:  img_height  = value;
            CSR_BPP:         bpp_reg     = value[2:0];
            CSR_STRIP_PX:    strip_px    = value;
            default: ;
         endcase
         update_geom();
      endfunction

      function void expect_byte(logic [7:0] data, logic last);
         strip_byte_type e;
         e.data = data;
         e.last = last;
         expected_q.push_back(e);
      endfunction

      function void note_input(logic [7:0] b, logic first);
         logic [31:0] field;
         int unsigned p;
         bit          last_row;
         bit          row_end;
         n_inputs++;
         if (first) begin
            header_pos   = '0;
            row_index    = '0;
            row_byte_pos = '0;
            file_done    = 1'b0;
         end
         if (file_done) return;

         // header: copied, three little-endian fields rewritten
         if (header_pos < header_len) begin
            if (header_pos >= OFS_FILE_SIZE && header_pos < OFS_FILE_SIZE + FIELD_BYTES)
               field = fsize >> (8 * (header_pos - OFS_FILE_SIZE));
            else if (header_pos >= OFS_WIDTH && header_pos < OFS_WIDTH + FIELD_BYTES)
               field = sw >> (8 * (header_pos - OFS_WIDTH));
            else if (header_pos >= OFS_DATA_SIZE && header_pos < OFS_DATA_SIZE + FIELD_BYTES)
               field = dsize >> (8 * (header_pos - OFS_DATA_SIZE));
            else
               field = {24'd0, b};
            expect_byte(field[7:0], 1'b0);
            header_pos = header_pos + 10'd1;
            return;
         end

         // pixel rows: keep the strip, pad it out to a multiple of 4 bytes
         p        = row_byte_pos;
         last_row = (row_index + 1 >= h);
         if (p >= s0 && p < s1) begin
            row_end = (p + 1 == s1);
            expect_byte(b, row_end && last_row && spad == 0);
            if (row_end) begin
               for (int i = 0; i < spad; i++)
                  expect_byte(8'h00, last_row && (i + 1 == spad));
               if (last_row) file_done = 1'b1;
            end
         end
         p++;
         if (p >= irow) begin
            p         = 0;
            row_index = row_index + 14'd1;
         end
         row_byte_pos = p[16:0];
      endfunction

      task report(string msg);
         n_mismatch++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(logic [7:0] data, logic last);
         strip_byte_type e;
         n_checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("output word %0d (0x%02h last %0b) with none expected",
                             n_checked, data, last));
            return;
         end
         e = expected_q.pop_front();
         if (data !== e.data)
            report($sformatf("output word %0d: byte 0x%02h, expected 0x%02h",
                             n_checked, data, e.data));
         if (last !== e.last)
            report($sformatf("output word %0d: last %0b, expected %0b",
                             n_checked, last, e.last));
      endtask
   endclass

   strip_scoreboard sb;
   bit tx_fast     = 1'b0;
   bit rx_fast     = 1'b0;
   bit hold_rsp    = 1'b0;
   int n_holds     = 0;
   int n_runs      = 0;
   int quiet_cycles = 0;

   bmp_center_strip_crop u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // all handshakes observed in one place, input before output
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // watchdog: too long without any word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Timed out after %0d idle cycles, %0d words still expected",
                  WATCHDOG_LIMIT, sb.expected_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // output side: random gaps, fast stretches, one long hold on request
   initial begin : receiver
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
            n_holds++;
         end
         if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
         gap = rx_fast ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic write_csr(input logic [2:0] index, input logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int unsigned hl, iw, ih, ib, isw);
      write_csr(CSR_HEADER_LEN, 15'(hl));
      write_csr(CSR_IMG_WIDTH, 15'(iw));
      write_csr(CSR_IMG_HEIGHT, 15'(ih));
      write_csr(CSR_BPP, 15'(ib));
      write_csr(CSR_STRIP_PX, 15'(isw));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_word(input logic [7:0] value, input logic first);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input int unsigned n, input bit mark_first);
      for (int i = 0; i < n; i++)
         send_word(8'($urandom_range(0, 255)), mark_first && i == 0);
      if (mark_first) n_runs++;
   endtask

   // stop sending and wait until every predicted word is out
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned hl, len, cut, kind;
      int unsigned rand_words;
      sb = new();
      rand_words = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero geometry: one pixel, three pad bytes, then dropped bytes
      configure(0, 0, 0, 0, 0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hA5, 1'b0);
      drain();

      // small complete file with a short header holding the size field
      configure(6, 2, 2, 1, 1);
      send_run(sb.file_len(), 1'b1);
      drain();

      // oversized width, depth and strip all clip
      configure(0, 32767, 1, 7, 32767);
      send_run(4, 1'b1);
      drain();

      // header length cut below the current position mid-file
      configure(40, 3, 2, 3, 2);
      send_run(3, 1'b1);
      drain();
      configure(2, 3, 2, 3, 2);
      send_run(3, 1'b0);
      drain();

      // longest header with largest geometry, header part only
      configure(1023, 32767, 16384, 7, 32767);
      send_run(20, 1'b1);
      drain();

      // output held off while the input keeps coming
      hold_rsp = 1'b1;
      tx_fast  = 1'b1;
      configure(0, 32767, 32767, 7, 32767);
      send_run(24, 1'b1);
      drain();

      // widest image with the strip starting one byte in
      tx_fast = 1'b0;
      configure(0, 16384, 2, 1, 16382);
      send_run(8, 1'b1);
      drain();

      // random small files, some cut short and restarted, some with trailing junk
      while (rand_words < RANDOM_WORDS) begin
         kind = $urandom_range(0, 3);
         if (kind == 0)      hl = $urandom_range(54, 58);
         else if (kind == 3) hl = $urandom_range(0, 12);
         else                hl = $urandom_range(0, 40);
         configure(hl, $urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 6),
                   $urandom_range(0, 8));
         tx_fast = ($urandom_range(0, 2) == 0);
         len  = sb.file_len();
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            cut = $urandom_range(1, len);
            send_run(cut, 1'b1);
            rand_words += cut;
         end
         send_run(len, 1'b1);
         rand_words += len;
         if (kind >= 8) send_run($urandom_range(1, 4), 1'b0);
         drain();
      end

      $display("Covered %0d files or partial files, %0d register writes, %0d input words",
               n_runs, sb.n_writes, sb.n_inputs);
      $display("Checked %0d output words; long output holds with input backed up: %0d",
               sb.n_checked, n_holds);
      if (sb.n_mismatch == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
